/* hw/rtl/mandelbrot_escape_time_pixel_unit_assert.svh */
// Assertion macros for the Mandelbrot escape-time pixel unit checkers.
// Expects clk_i and rst_ni in scope where a macro is used.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_ASSERT_SVH

// Check while out of reset.
`define MEPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define MEPU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/mepu_pkg.sv */
// Types, constants and helpers for the Mandelbrot escape-time pixel unit.
// No dependencies.
package mepu_pkg;

  localparam int unsigned COORD_W   = 14;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned GREY_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAC_BITS = 28;

  localparam logic signed [DATA_W-1:0] X_OFFSET_RST = -32'sd536870912;
  localparam logic signed [DATA_W-1:0] Y_OFFSET_RST = -32'sd268435456;
  localparam logic [STEP_W-1:0]        X_STEP_RST   = 31'd786432;
  localparam logic [STEP_W-1:0]        Y_STEP_RST   = 31'd524288;

  localparam logic [PROD_W-1:0] ESC_LIMIT = 64'd4 << (2 * FRAC_BITS);

  localparam int unsigned GREY_MUL = 255;
  localparam int unsigned GREY_DIV = 70;
  localparam int unsigned GREY_INC = GREY_MUL / GREY_DIV;
  localparam int unsigned GREY_REM = GREY_MUL % GREY_DIV;
  localparam int unsigned REM_W    = $clog2(GREY_DIV);
  localparam logic [GREY_W-1:0] GREY_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_OFFSET = 2'd0,
    CFG_Y_OFFSET = 2'd1,
    CFG_X_STEP   = 2'd2,
    CFG_Y_STEP   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_POINT,
    ST_MUL,
    ST_UPD
  } state_e;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

/* hw/rtl/mandelbrot_escape_time_pixel_unit.sv */
// Mandelbrot escape-time pixel unit: maps a pixel to c, iterates z = z^2 + c.
// Depends on mepu_pkg.
//
//   channel   handshake                 payload
//   config    cfg_we_i                  cfg_idx_i, cfg_wdata_i
//   pixel     start && !busy            pixel_col_i, pixel_row_i
//   result    valid_o (one-cycle)       out_col_o, out_row_o, grey_o
//
// busy stays high from acceptance until the result is issued; a run ends at the escape
// step or after MAX_ITER steps. Each step passes ST_MUL, through the shared
// three-multiplier unit, then ST_UPD for shift, add, saturate and the escape test.
// valid_o pulses in the cycle busy drops; a new word may be started then.
// Reset loads the default view and returns to idle. The receiver cannot stall.
module mandelbrot_escape_time_pixel_unit #(
  parameter int unsigned MAX_ITER = 200
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mepu_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [mepu_pkg::DATA_W-1:0]            cfg_wdata_i,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [mepu_pkg::COORD_W-1:0]           pixel_col_i,
  input  logic [mepu_pkg::COORD_W-1:0]           pixel_row_i,
  output logic                                   valid_o,
  output logic [mepu_pkg::COORD_W-1:0]           out_col_o,
  output logic [mepu_pkg::COORD_W-1:0]           out_row_o,
  output logic [mepu_pkg::GREY_W-1:0]            grey_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ITER + 1);
  localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(MAX_ITER);
  localparam int unsigned PAD_W = mepu_pkg::DATA_W - mepu_pkg::COORD_W;

  mepu_pkg::state_e state_q, state_d;

  logic signed [mepu_pkg::DATA_W-1:0] x_off_q, x_off_d, y_off_q, y_off_d;
  logic [mepu_pkg::STEP_W-1:0]        x_step_q, x_step_d, y_step_q, y_step_d;

  logic [mepu_pkg::COORD_W-1:0]       col_q, col_d, row_q, row_d;
  logic signed [mepu_pkg::DATA_W-1:0] zr_q, zr_d, zi_q, zi_d, cr_q, cr_d, ci_q, ci_d;
  logic signed [mepu_pkg::PROD_W-1:0] p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;
  logic [CNT_W-1:0]                   cnt_q, cnt_d;
  logic [mepu_pkg::GREY_W-1:0]        g_q, g_d;
  logic [mepu_pkg::REM_W-1:0]         r_q, r_d;

  logic                               valid_q, valid_d;
  logic [mepu_pkg::COORD_W-1:0]       ocol_q, ocol_d, orow_q, orow_d;
  logic [mepu_pkg::GREY_W-1:0]        ogrey_q, ogrey_d;

  logic signed [mepu_pkg::DATA_W-1:0] a0, b0, a1, b1, a2, b2;
  logic signed [mepu_pkg::PROD_W-1:0] m0, m1, m2;

  logic [mepu_pkg::PROD_W-1:0]        sq_sum;
  logic                               escaped;
  logic                               last_step;
  logic signed [mepu_pkg::PROD_W-1:0] diff, cross2, re_part, im_part;
  logic signed [mepu_pkg::DATA_W-1:0] zr_new, zi_new;
  logic [mepu_pkg::REM_W:0]           r_sum;
  logic                               r_carry;
  logic [mepu_pkg::REM_W-1:0]         r_new;
  logic [mepu_pkg::GREY_W:0]          g_sum;
  logic [mepu_pkg::GREY_W-1:0]        g_new;

  // shared multiplier unit
  always_comb begin
    if (state_q == mepu_pkg::ST_MAP) begin
      a0 = {{PAD_W{1'b0}}, col_q};
      b0 = {1'b0, x_step_q};
      a1 = {{PAD_W{1'b0}}, row_q};
      b1 = {1'b0, y_step_q};
      a2 = zr_q;
      b2 = zi_q;
    end else begin
      a0 = zr_q;
      b0 = zr_q;
      a1 = zi_q;
      b1 = zi_q;
      a2 = zr_q;
      b2 = zi_q;
    end
  end

  assign m0 = a0 * b0;
  assign m1 = a1 * b1;
  assign m2 = a2 * b2;

  // escape test and update from registered products
  assign sq_sum    = unsigned'(p0_q) + unsigned'(p1_q);
  assign escaped   = (cnt_q != '0) && (sq_sum > mepu_pkg::ESC_LIMIT);
  assign last_step = (cnt_q == ITER_LAST);
  assign diff      = p0_q - p1_q;
  assign cross2    = p2_q <<< 1;
  assign re_part   = diff >>> mepu_pkg::FRAC_BITS;
  assign im_part   = cross2 >>> mepu_pkg::FRAC_BITS;
  assign zr_new    = mepu_pkg::sat32(re_part + 64'(cr_q));
  assign zi_new    = mepu_pkg::sat32(im_part + 64'(ci_q));

  // grey tracks floor(k * 255 / 70) for the last step k, saturating
  assign r_sum   = {1'b0, r_q} + (mepu_pkg::REM_W + 1)'(mepu_pkg::GREY_REM);
  assign r_carry = (r_sum >= (mepu_pkg::REM_W + 1)'(mepu_pkg::GREY_DIV));
  assign r_new   = r_carry
                 ? mepu_pkg::REM_W'(r_sum - (mepu_pkg::REM_W + 1)'(mepu_pkg::GREY_DIV))
                 : r_sum[mepu_pkg::REM_W-1:0];
  assign g_sum   = {1'b0, g_q} + (mepu_pkg::GREY_W + 1)'(mepu_pkg::GREY_INC)
                 + (mepu_pkg::GREY_W + 1)'(r_carry);
  assign g_new   = g_sum[mepu_pkg::GREY_W] ? mepu_pkg::GREY_MAX : g_sum[mepu_pkg::GREY_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mepu_pkg::ST_IDLE:  if (start) state_d = mepu_pkg::ST_MAP;
      mepu_pkg::ST_MAP:   state_d = mepu_pkg::ST_POINT;
      mepu_pkg::ST_POINT: state_d = mepu_pkg::ST_MUL;
      mepu_pkg::ST_MUL:   state_d = mepu_pkg::ST_UPD;
      mepu_pkg::ST_UPD: begin
        if (escaped || last_step) begin
          state_d = mepu_pkg::ST_IDLE;
        end else begin
          state_d = mepu_pkg::ST_MUL;
        end
      end
      default: state_d = mepu_pkg::ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    p0_d    = p0_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    cnt_d   = cnt_q;
    g_d     = g_q;
    r_d     = r_q;
    valid_d = 1'b0;
    ocol_d  = ocol_q;
    orow_d  = orow_q;
    ogrey_d = ogrey_q;
    unique case (state_q)
      mepu_pkg::ST_IDLE: begin
        if (start) begin
          col_d = pixel_col_i;
          row_d = pixel_row_i;
        end
      end
      mepu_pkg::ST_MAP, mepu_pkg::ST_MUL: begin
        p0_d = m0;
        p1_d = m1;
        p2_d = m2;
      end
      mepu_pkg::ST_POINT: begin
        cr_d  = mepu_pkg::sat32(p0_q + 64'(x_off_q));
        ci_d  = mepu_pkg::sat32(p1_q + 64'(y_off_q));
        zr_d  = '0;
        zi_d  = '0;
        cnt_d = '0;
        g_d   = '0;
        r_d   = '0;
      end
      mepu_pkg::ST_UPD: begin
        if (escaped || last_step) begin
          valid_d = 1'b1;
          ocol_d  = col_q;
          orow_d  = row_q;
          ogrey_d = escaped ? g_q : mepu_pkg::GREY_MAX;
        end else begin
          zr_d  = zr_new;
          zi_d  = zi_new;
          cnt_d = cnt_q + CNT_W'(1);
          if (cnt_q != '0) begin
            g_d = g_new;
            r_d = r_new;
          end
        end
      end
      default: ;
    endcase
  end

  // configuration writes
  always_comb begin
    x_off_d  = x_off_q;
    y_off_d  = y_off_q;
    x_step_d = x_step_q;
    y_step_d = y_step_q;
    if (cfg_we_i) begin
      unique case (mepu_pkg::cfg_idx_e'(cfg_idx_i))
        mepu_pkg::CFG_X_OFFSET: x_off_d  = cfg_wdata_i;
        mepu_pkg::CFG_Y_OFFSET: y_off_d  = cfg_wdata_i;
        mepu_pkg::CFG_X_STEP:   x_step_d = cfg_wdata_i[mepu_pkg::STEP_W-1:0];
        mepu_pkg::CFG_Y_STEP:   y_step_d = cfg_wdata_i[mepu_pkg::STEP_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mepu_pkg::ST_IDLE;
      valid_q  <= 1'b0;
      x_off_q  <= mepu_pkg::X_OFFSET_RST;
      y_off_q  <= mepu_pkg::Y_OFFSET_RST;
      x_step_q <= mepu_pkg::X_STEP_RST;
      y_step_q <= mepu_pkg::Y_STEP_RST;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      x_off_q  <= x_off_d;
      y_off_q  <= y_off_d;
      x_step_q <= x_step_d;
      y_step_q <= y_step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    row_q   <= row_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    cr_q    <= cr_d;
    ci_q    <= ci_d;
    p0_q    <= p0_d;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    cnt_q   <= cnt_d;
    g_q     <= g_d;
    r_q     <= r_d;
    ocol_q  <= ocol_d;
    orow_q  <= orow_d;
    ogrey_q <= ogrey_d;
  end

  assign busy      = (state_q != mepu_pkg::ST_IDLE);
  assign valid_o   = valid_q;
  assign out_col_o = ocol_q;
  assign out_row_o = orow_q;
  assign grey_o    = ogrey_q;

endmodule

/* hw/rtl/mepu_checker.sv */
// Port-level checker for the Mandelbrot escape-time pixel unit, plus its bind.
// Depends on mandelbrot_escape_time_pixel_unit_assert.svh.
`include "mandelbrot_escape_time_pixel_unit_assert.svh"

module mepu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o
);

  `MEPU_ASSERT(a_start_takes, (start && !busy) |=> busy, "accepted word did not raise busy")
  `MEPU_ASSERT(a_done_on_fall, $fell(busy) |-> valid_o, "busy dropped without a result")
  `MEPU_ASSERT(a_result_idle, valid_o |-> !busy, "result strobe while still busy")
  `MEPU_ASSERT(a_strobe_single, valid_o |=> !valid_o, "result strobe longer than one cycle")
  `MEPU_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!busy && !valid_o), "activity after reset")

endmodule

bind mandelbrot_escape_time_pixel_unit mepu_checker u_mepu_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the Mandelbrot escape-time pixel unit.
// Drives pixel words and register writes, predicts each grey level in fixed point
// and checks every result word in order. Depends on mepu_pkg and the unit RTL.
module testbench;

  localparam int unsigned PIXEL_ITER = 200;

  typedef struct packed {
    logic [mepu_pkg::COORD_W-1:0] col;
    logic [mepu_pkg::COORD_W-1:0] row;
    logic [mepu_pkg::GREY_W-1:0]  grey;
  } pixel_word_t;

  class pixel_scoreboard;
    longint      x_off  = mepu_pkg::X_OFFSET_RST;
    longint      y_off  = mepu_pkg::Y_OFFSET_RST;
    longint      x_step = mepu_pkg::X_STEP_RST;
    longint      y_step = mepu_pkg::Y_STEP_RST;
    pixel_word_t pending_pixels[$];
    int          errors;

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function void set_reg(mepu_pkg::cfg_idx_e idx, logic [mepu_pkg::DATA_W-1:0] data);
      case (idx)
        mepu_pkg::CFG_X_OFFSET: x_off  = longint'(signed'(data));
        mepu_pkg::CFG_Y_OFFSET: y_off  = longint'(signed'(data));
        mepu_pkg::CFG_X_STEP:   x_step = longint'({33'b0, data[mepu_pkg::STEP_W-1:0]});
        mepu_pkg::CFG_Y_STEP:   y_step = longint'({33'b0, data[mepu_pkg::STEP_W-1:0]});
        default: ;
      endcase
    endfunction

    // steps: escape index, or PIXEL_ITER when the orbit stays bounded
    function logic [mepu_pkg::GREY_W-1:0] escape_grey(logic [mepu_pkg::COORD_W-1:0] col,
                                                       logic [mepu_pkg::COORD_W-1:0] row,
                                                       output int steps);
      longint      cr, ci, zr, zi, re, im;
      logic [63:0] sq_r, sq_i;
      int          g;
      cr = clamp32(longint'(col) * x_step + x_off);
      ci = clamp32(longint'(row) * y_step + y_off);
      zr = 0;
      zi = 0;
      steps = PIXEL_ITER;
      escape_grey = mepu_pkg::GREY_MAX;
      for (int i = 0; i < PIXEL_ITER; i++) begin
        re = (zr * zr - zi * zi) >>> mepu_pkg::FRAC_BITS;
        im = (2 * zr * zi) >>> mepu_pkg::FRAC_BITS;
        zr = clamp32(re + cr);
        zi = clamp32(im + ci);
        sq_r = zr * zr;
        sq_i = zi * zi;
        if (sq_r + sq_i > mepu_pkg::ESC_LIMIT) begin
          steps = i;
          g = (i * mepu_pkg::GREY_MUL) / mepu_pkg::GREY_DIV;
          escape_grey = (g > 255) ? mepu_pkg::GREY_MAX : g[mepu_pkg::GREY_W-1:0];
          break;
        end
      end
    endfunction

    function void note_pixel(logic [mepu_pkg::COORD_W-1:0] col,
                             logic [mepu_pkg::COORD_W-1:0] row);
      pixel_word_t w;
      int          steps;
      w.col  = col;
      w.row  = row;
      w.grey = escape_grey(col, row, steps);
      pending_pixels.push_back(w);
    endfunction

    task report_mismatch(string msg);
      if (errors < 100) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
      errors++;
    endtask

    task check_result(logic [mepu_pkg::COORD_W-1:0] col, logic [mepu_pkg::COORD_W-1:0] row,
                      logic [mepu_pkg::GREY_W-1:0] grey);
      pixel_word_t w;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected word col %0d row %0d grey %0d", col, row, grey));
      end else begin
        w = pending_pixels.pop_front();
        if (col !== w.col) begin
          report_mismatch($sformatf("col %0d, want %0d", col, w.col));
        end
        if (row !== w.row) begin
          report_mismatch($sformatf("row %0d, want %0d", row, w.row));
        end
        if (grey !== w.grey) begin
          report_mismatch($sformatf("grey %0d, want %0d (col %0d row %0d)",
                                    grey, w.grey, w.col, w.row));
        end
      end
    endtask
  endclass

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [mepu_pkg::CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [mepu_pkg::DATA_W-1:0]    cfg_wdata_i = '0;
  logic                           start       = 1'b0;
  logic                           busy;
  logic [mepu_pkg::COORD_W-1:0]   pixel_col_i = '0;
  logic [mepu_pkg::COORD_W-1:0]   pixel_row_i = '0;
  logic                           valid_o;
  logic [mepu_pkg::COORD_W-1:0]   out_col_o;
  logic [mepu_pkg::COORD_W-1:0]   out_row_o;
  logic [mepu_pkg::GREY_W-1:0]    grey_o;

  pixel_scoreboard sb;

  mandelbrot_escape_time_pixel_unit #(
    .MAX_ITER(PIXEL_ITER)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .pixel_col_i (pixel_col_i),
    .pixel_row_i (pixel_row_i),
    .valid_o     (valid_o),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o),
    .grey_o      (grey_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sb.check_result(out_col_o, out_row_o, grey_o);
    end
  end

  task automatic write_reg(mepu_pkg::cfg_idx_e idx, logic [mepu_pkg::DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // start stays high after acceptance; the caller drops it when it idles
  task automatic send_pixel(logic [mepu_pkg::COORD_W-1:0] col,
                            logic [mepu_pkg::COORD_W-1:0] row);
    @(negedge clk_i);
    start       <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    do @(posedge clk_i); while (busy);
    sb.note_pixel(col, row);
  endtask

  task automatic run_pixels(int count, bit wide, bit quiet);
    int gap;
    for (int k = 0; k < count; k++) begin
      if (!quiet && $urandom_range(99) < 17) begin
        gap = ($urandom_range(9) == 0) ? $urandom_range(450) + 1 : $urandom_range(8, 1);
        @(negedge clk_i);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      if (wide) begin
        send_pixel(mepu_pkg::COORD_W'($urandom_range(16383)),
                   mepu_pkg::COORD_W'($urandom_range(16383)));
      end else begin
        send_pixel(mepu_pkg::COORD_W'($urandom_range(1023)),
                   mepu_pkg::COORD_W'($urandom_range(1023)));
      end
    end
  endtask

  task automatic drain_pixels();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    int          steps;
    bit          found;
    sb = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default view: corners, bit patterns, bounded orbits, the real-axis cusp
    send_pixel(14'd0, 14'd0);
    send_pixel(14'h3FFF, 14'h3FFF);
    send_pixel(14'h3FFF, 14'd0);
    send_pixel(14'd0, 14'h3FFF);
    send_pixel(14'h2AAA, 14'h1555);
    send_pixel(14'h1555, 14'h2AAA);
    send_pixel(14'd400, 14'd512);
    send_pixel(14'd682, 14'd512);
    send_pixel(14'd768, 14'd512);
    send_pixel(14'd769, 14'd512);
    send_pixel(14'd1023, 14'd1023);
    send_pixel(14'd341, 14'd512);
    send_pixel(14'd100, 14'd900);
    // find points escaping late enough to clip the grey scale, and a few mid-range ones
    found = 1'b0;
    for (int r = 0; r < 1024 && !found; r += 64) begin
      for (int c = 0; c < 1024 && !found; c += 4) begin
        void'(sb.escape_grey(mepu_pkg::COORD_W'(c), mepu_pkg::COORD_W'(r), steps));
        if (steps >= 71 && steps < PIXEL_ITER) begin
          found = 1'b1;
          send_pixel(mepu_pkg::COORD_W'(c), mepu_pkg::COORD_W'(r));
          send_pixel(mepu_pkg::COORD_W'(c), mepu_pkg::COORD_W'(r + 1));
        end else if (steps >= 10 && steps < 71 && $urandom_range(199) == 0) begin
          send_pixel(mepu_pkg::COORD_W'(c), mepu_pkg::COORD_W'(r));
        end
      end
    end
    drain_pixels();

    run_pixels(150, 1'b0, 1'b0);
    run_pixels(150, 1'b0, 1'b1);
    drain_pixels();
    run_pixels(70, 1'b0, 1'b0);
    run_pixels(30, 1'b1, 1'b0);
    drain_pixels();

    // zoomed views around the set
    repeat (3) begin
      write_reg(mepu_pkg::CFG_X_OFFSET, -536870912 + int'($urandom_range(617401548)));
      write_reg(mepu_pkg::CFG_Y_OFFSET, -322122547 + int'($urandom_range(644245094)));
      write_reg(mepu_pkg::CFG_X_STEP, $urandom_range(65536, 1024));
      write_reg(mepu_pkg::CFG_Y_STEP, $urandom_range(65536, 1024));
      run_pixels(170, 1'b0, 1'b0);
      drain_pixels();
    end

    // saturated corners; bit 31 of a step write is dropped
    write_reg(mepu_pkg::CFG_X_OFFSET, 32'h8000_0000);
    write_reg(mepu_pkg::CFG_Y_OFFSET, 32'h7FFF_FFFF);
    write_reg(mepu_pkg::CFG_X_STEP, 32'hFFFF_FFFF);
    write_reg(mepu_pkg::CFG_Y_STEP, 32'h7FFF_FFFF);
    run_pixels(100, 1'b1, 1'b0);
    drain_pixels();
    write_reg(mepu_pkg::CFG_X_OFFSET, 32'h7FFF_FFFF);
    write_reg(mepu_pkg::CFG_Y_OFFSET, 32'h8000_0000);
    write_reg(mepu_pkg::CFG_X_STEP, 32'h0000_0000);
    write_reg(mepu_pkg::CFG_Y_STEP, 32'h0000_0000);
    run_pixels(50, 1'b1, 1'b0);
    drain_pixels();

    // every pixel maps to the origin and never escapes
    write_reg(mepu_pkg::CFG_X_OFFSET, 32'h0000_0000);
    write_reg(mepu_pkg::CFG_Y_OFFSET, 32'h0000_0000);
    write_reg(mepu_pkg::CFG_X_STEP, 32'h8000_0000);
    run_pixels(15, 1'b1, 1'b0);
    drain_pixels();

    repeat (2) begin
      write_reg(mepu_pkg::CFG_X_OFFSET, $urandom());
      write_reg(mepu_pkg::CFG_Y_OFFSET, $urandom());
      write_reg(mepu_pkg::CFG_X_STEP, $urandom());
      write_reg(mepu_pkg::CFG_Y_STEP, $urandom());
      run_pixels(100, 1'b1, 1'b0);
      drain_pixels();
    end

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
